// File: design/mfmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MFM deserializer package
// Shared types, constants and helpers for the MFM cell-bit deserializer.
// ----------------------------------------------------------------------------
package mfmd_pkg;

    localparam int unsigned WINDOW_W   = 16;
    localparam int unsigned POS_W      = 5;
    localparam int unsigned RUN_W      = 2;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // cells per decoded byte, and the sync run value that arms mark detection
    localparam logic [POS_W-1:0] BYTE_CELLS = POS_W'(16);
    localparam logic [RUN_W-1:0] RUN_FULL   = RUN_W'(3);

    // register reset values
    localparam logic [WINDOW_W-1:0] RST_SYNC_A1  = 16'h4489;
    localparam logic [WINDOW_W-1:0] RST_SYNC_C2  = 16'h5224;
    localparam logic [BYTE_W-1:0]   RST_ID_MARK  = 8'hFE;
    localparam logic [BYTE_W-1:0]   RST_DAT_MARK = 8'hFB;
    localparam logic [BYTE_W-1:0]   RST_DEL_MARK = 8'hF8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_A1  = 3'd0,
        CFG_SYNC_C2  = 3'd1,
        CFG_ID_MARK  = 3'd2,
        CFG_DAT_MARK = 3'd3,
        CFG_DEL_MARK = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MARK_NONE    = 2'd0,
        MARK_ID      = 2'd1,
        MARK_DATA    = 2'd2,
        MARK_DELETED = 2'd3
    } t_mark_kind;

    typedef struct packed {
        logic [WINDOW_W-1:0] sync_a1;
        logic [WINDOW_W-1:0] sync_c2;
        logic [BYTE_W-1:0]   id_mark;
        logic [BYTE_W-1:0]   dat_mark;
        logic [BYTE_W-1:0]   del_mark;
    } t_cfg;

    typedef struct packed {
        logic [WINDOW_W-1:0] window;
        logic [POS_W-1:0]    pos;
        logic [RUN_W-1:0]    run;
        logic                armed;
    } t_state;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              byte_valid;
        logic              sync_seen;
        t_mark_kind        mark_kind;
    } t_result;

    // data bits sit at the even cell positions, MSB first
    function automatic logic [BYTE_W-1:0] even_bits(input logic [WINDOW_W-1:0] w);
        logic [BYTE_W-1:0] b;
        for (int i = 0; i < BYTE_W; i++) begin
            b[i] = w[2*i];
        end
        return b;
    endfunction

endpackage

// File: design/mfmd_bit_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MFM cell-bit channel
// Valid/ready channel carrying one raw cell bit per item.
// ----------------------------------------------------------------------------
interface mfmd_bit_if;
    logic valid;
    logic ready;
    logic cell_bit;

    modport source (output valid, output cell_bit, input ready);
    modport sink   (input valid, input cell_bit, output ready);
endinterface

// File: design/mfmd_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MFM result channel
// Valid/ready channel carrying one decode result per item.
// ----------------------------------------------------------------------------
interface mfmd_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       sync_seen;
    logic [1:0] mark_kind;

    modport source (output valid, output data_byte, output byte_valid,
                    output sync_seen, output mark_kind, input ready);
    modport sink   (input valid, input data_byte, input byte_valid,
                    input sync_seen, input mark_kind, output ready);
endinterface

// File: design/mfmd_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MFM decode step
// Next state and result for one cell bit: window shift, sync match,
// byte framing and address-mark classification.
// ----------------------------------------------------------------------------
module mfmd_step (
    input  mfmd_pkg::t_cfg    i_cfg,
    input  mfmd_pkg::t_state  i_state,
    input  logic              i_cell_bit,
    output mfmd_pkg::t_state  o_state,
    output mfmd_pkg::t_result o_result
);
    import mfmd_pkg::*;

    logic [WINDOW_W-1:0] win;
    logic [POS_W-1:0]    pos_inc;
    logic [RUN_W-1:0]    run_a1;
    logic [BYTE_W-1:0]   dec_byte;
    t_mark_kind          kind;

    assign win      = {i_state.window[WINDOW_W-2:0], i_cell_bit};
    assign pos_inc  = i_state.pos + POS_W'(1);
    assign run_a1   = (i_state.run < RUN_FULL) ? i_state.run + RUN_W'(1) : i_state.run;
    assign dec_byte = even_bits(win);

    // ID mark wins over data, data over deleted
    always_comb begin
        priority if (dec_byte == i_cfg.id_mark)  kind = MARK_ID;
        else if     (dec_byte == i_cfg.dat_mark) kind = MARK_DATA;
        else if     (dec_byte == i_cfg.del_mark) kind = MARK_DELETED;
        else                                     kind = MARK_NONE;
    end

    always_comb begin
        o_state         = i_state;
        o_state.window  = win;
        o_state.pos     = pos_inc;
        o_result        = '{data_byte: '0, byte_valid: 1'b0, sync_seen: 1'b0,
                            mark_kind: MARK_NONE};
        priority if (win == i_cfg.sync_a1) begin
            o_result.sync_seen = 1'b1;
            o_state.pos        = '0;
            o_state.run        = run_a1;
            if (run_a1 == RUN_FULL) begin
                o_state.armed = 1'b1;
            end
        end else if (win == i_cfg.sync_c2) begin
            o_result.sync_seen = 1'b1;
            o_state.pos        = '0;
            o_state.run        = '0;
        end else if (pos_inc == BYTE_CELLS) begin
            o_result.data_byte  = dec_byte;
            o_result.byte_valid = 1'b1;
            o_state.pos         = '0;
            o_state.run         = '0;
            if (i_state.armed) begin
                o_state.armed      = 1'b0;
                o_result.mark_kind = kind;
            end
        end
    end
endmodule

// File: design/mfm_bit_deserializer_sync.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MFM bit deserializer with sync detect
// Deserializes raw MFM cell bits into bytes, spots A1/C2 sync patterns and
// classifies address marks following a run of three A1 syncs.
// ----------------------------------------------------------------------------
// Usage:
//   i_bit  : one raw cell bit per item (valid/ready).
//   o_res  : exactly one result item per input item: data_byte/byte_valid
//            when a 16-cell byte completes, sync_seen on an A1 or C2 match,
//            mark_kind (0 none, 1 ID, 2 data, 3 deleted) on the first byte
//            after three A1 syncs. data_byte reads 0 when byte_valid is low.
//   i_cfg_*: register write port (index 0 A1 pattern, 1 C2 pattern, 2 ID mark,
//            3 data mark, 4 deleted mark); other indexes are dropped. Write
//            only while no item is in flight.
// An accepted item's result is registered and shows on o_res in the cycle after it is taken.
// Throughput is one item per cycle unless o_res stalls; the decode step is
// a single combinational pass between the state registers and result register.
// The result register decouples the sides: a new bit is taken while a result
// waits, as long as the receiver takes that result in the same cycle. While
// the receiver stalls, i_bit.ready drops and window state holds.
// Synchronous active-low reset clears window, bit count, sync run, mark
// arming and result valid, and reloads the default patterns and mark bytes.
// ----------------------------------------------------------------------------
module mfm_bit_deserializer_sync (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    mfmd_bit_if.sink                              i_bit,
    mfmd_res_if.source                            o_res,
    input  logic                                  i_cfg_we,
    input  logic [mfmd_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [mfmd_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import mfmd_pkg::*;

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result r_res;
    t_result n_res;
    logic    r_out_valid;
    logic    in_take;

    // ---- configuration registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{sync_a1: RST_SYNC_A1, sync_c2: RST_SYNC_C2,
                       id_mark: RST_ID_MARK, dat_mark: RST_DAT_MARK,
                       del_mark: RST_DEL_MARK};
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SYNC_A1:  r_cfg.sync_a1  <= i_cfg_data;
                CFG_SYNC_C2:  r_cfg.sync_c2  <= i_cfg_data;
                CFG_ID_MARK:  r_cfg.id_mark  <= i_cfg_data[BYTE_W-1:0];
                CFG_DAT_MARK: r_cfg.dat_mark <= i_cfg_data[BYTE_W-1:0];
                CFG_DEL_MARK: r_cfg.del_mark <= i_cfg_data[BYTE_W-1:0];
                default:      ;
            endcase
        end
    end

    // ---- handshake: take a bit when the result slot is free or draining ----
    assign i_bit.ready = !r_out_valid || o_res.ready;
    assign in_take     = i_bit.valid && i_bit.ready;

    // ---- decode step ----
    mfmd_step u_step (
        .i_cfg      (r_cfg),
        .i_state    (r_state),
        .i_cell_bit (i_bit.cell_bit),
        .o_state    (n_state),
        .o_result   (n_res)
    );

    // ---- decoder state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_take) begin
            r_state <= n_state;
        end
    end

    // ---- result register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_take) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.data_byte  = r_res.data_byte;
    assign o_res.byte_valid = r_res.byte_valid;
    assign o_res.sync_seen  = r_res.sync_seen;
    assign o_res.mark_kind  = r_res.mark_kind;

`ifndef NO_ASSERTIONS
    // bit count always restarts at the byte boundary
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.pos < BYTE_CELLS)
        else $error("bit count reached byte boundary without restart");

    // a full sync run means detection is armed
    a_run_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.run == RUN_FULL) |-> r_state.armed)
        else $error("sync run full but mark detection not armed");

    // a mark is only reported with a decoded byte, never with a sync
    a_mark_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.mark_kind != MARK_NONE) |-> r_res.byte_valid)
        else $error("mark reported without a byte");

    a_byte_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_res.byte_valid && r_res.sync_seen))
        else $error("byte and sync flagged together");

    // an emitted byte ends the sync run and disarms detection
    a_byte_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && n_res.byte_valid) |=> (r_state.run == '0 && !r_state.armed))
        else $error("byte did not clear sync run and arming");
`endif
endmodule
